// ===== sv/ppec_pkg.sv =====
// ----------------------------------------------------------------------------
// ppec_pkg
// Shared codes, register indexes and width helpers of the plane edge clipper.
// ----------------------------------------------------------------------------
package ppec_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int NORM_FRAC      = 30;
    localparam int CFG_W          = 32;
    localparam int CFG_ADDR_W     = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_X     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_Y     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_Z     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_OFFSET = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_KEEP_BIAS    = 3'd4;

    localparam logic [CFG_W-1:0] NORMAL_Z_RESET = 32'h4000_0000;

    localparam logic [1:0] KIND_EDGE    = 2'd0;
    localparam logic [1:0] KIND_CAP     = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [1:0] VERDICT_KEPT      = 2'd0;
    localparam logic [1:0] VERDICT_DISCARDED = 2'd1;
    localparam logic [1:0] VERDICT_CLIPPED   = 2'd2;

    localparam logic [1:0] CAP_NONE = 2'd0;
    localparam logic [1:0] CAP_OPEN = 2'd1;
    localparam logic [1:0] CAP_DONE = 2'd2;

    // signed distance width: three products plus the scaled offset
    function automatic int dist_bits(input int coord_bits);
        return (coord_bits + 34 > 64) ? coord_bits + 34 : 64;
    endfunction

    function automatic int entry_bits(input int coord_bits);
        return 6 * coord_bits + 2 * dist_bits(coord_bits) + 3;
    endfunction

endpackage

// ===== sv/ppec_queue.sv =====
// ----------------------------------------------------------------------------
// ppec_queue
// Two-entry queue between the classifying front and the clipping back.
// ----------------------------------------------------------------------------
module ppec_queue
#(
    parameter int WIDTH = 8
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== sv/ppec_front.sv =====
// ----------------------------------------------------------------------------
// ppec_front
// Takes edges, computes both signed distances with one shared multiplier and
// classifies the endpoints against the keep bias.
// ----------------------------------------------------------------------------
module ppec_front
    import ppec_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [COORD_BITS-1:0]        i_start_x,
    input  logic signed [COORD_BITS-1:0]        i_start_y,
    input  logic signed [COORD_BITS-1:0]        i_start_z,
    input  logic signed [COORD_BITS-1:0]        i_end_x,
    input  logic signed [COORD_BITS-1:0]        i_end_y,
    input  logic signed [COORD_BITS-1:0]        i_end_z,
    input  logic                                i_final_edge,
    input  logic signed [CFG_W-1:0]             i_normal_x,
    input  logic signed [CFG_W-1:0]             i_normal_y,
    input  logic signed [CFG_W-1:0]             i_normal_z,
    input  logic signed [CFG_W-1:0]             i_plane_offset,
    input  logic signed [CFG_W-1:0]             i_keep_bias,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output logic [entry_bits(COORD_BITS)-1:0]   o_q_data
);

    localparam int DW = dist_bits(COORD_BITS);
    localparam int PW = CFG_W + COORD_BITS;

    logic                         r_busy;
    logic [2:0]                   r_step;
    logic signed [COORD_BITS-1:0] r_p [6];
    logic                         r_fin;
    logic signed [PW-1:0]         r_prod;
    logic signed [DW-1:0]         r_d1;
    logic signed [DW-1:0]         r_d2;

    logic signed [CFG_W-1:0]      mul_n;
    logic signed [COORD_BITS-1:0] mul_c;
    logic signed [PW-1:0]         mul;
    logic signed [DW-1:0]         off_s;
    logic signed [DW-1:0]         bias_s;
    logic signed [DW-1:0]         prod_ext;
    logic                         accept;

    assign full     = r_busy;
    assign accept   = push && !r_busy;
    assign off_s    = {{(DW-CFG_W-NORM_FRAC){i_plane_offset[CFG_W-1]}}, i_plane_offset,
                       {NORM_FRAC{1'b0}}};
    assign bias_s   = {{(DW-CFG_W-NORM_FRAC){i_keep_bias[CFG_W-1]}}, i_keep_bias,
                       {NORM_FRAC{1'b0}}};
    assign prod_ext = {{(DW-PW){r_prod[PW-1]}}, r_prod};
    assign mul      = mul_n * mul_c;
    assign o_q_push = r_busy && (r_step == 3'd7) && !i_q_full;
    assign o_q_data = {r_p[0], r_p[1], r_p[2], r_p[3], r_p[4], r_p[5], r_d1, r_d2,
                       (r_d1 < bias_s), (r_d2 < bias_s), r_fin};

    always_comb begin
        case (r_step)
            3'd0: begin mul_n = i_normal_x; mul_c = r_p[0]; end
            3'd1: begin mul_n = i_normal_y; mul_c = r_p[1]; end
            3'd2: begin mul_n = i_normal_z; mul_c = r_p[2]; end
            3'd3: begin mul_n = i_normal_x; mul_c = r_p[3]; end
            3'd4: begin mul_n = i_normal_y; mul_c = r_p[4]; end
            3'd5: begin mul_n = i_normal_z; mul_c = r_p[5]; end
            default: begin mul_n = i_normal_x; mul_c = r_p[0]; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 3'd0;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_step <= 3'd0;
        end else if (r_busy) begin
            if (r_step != 3'd7) begin
                r_step <= r_step + 3'd1;
            end else if (!i_q_full) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p[0] <= i_start_x;
            r_p[1] <= i_start_y;
            r_p[2] <= i_start_z;
            r_p[3] <= i_end_x;
            r_p[4] <= i_end_y;
            r_p[5] <= i_end_z;
            r_fin  <= i_final_edge;
            r_d1   <= off_s;
            r_d2   <= off_s;
        end else if (r_busy) begin
            if (r_step <= 3'd5) begin
                r_prod <= mul;
            end
            if (r_step >= 3'd1 && r_step <= 3'd3) begin
                r_d1 <= r_d1 + prod_ext;
            end else if (r_step >= 3'd4 && r_step <= 3'd6) begin
                r_d2 <= r_d2 + prod_ext;
            end
        end
    end

endmodule

// ===== sv/ppec_back.sv =====
// ----------------------------------------------------------------------------
// ppec_back
// Clips queued edges, tracks the cap edge and polygon verdict, and holds the
// result beat in an output register.
// ----------------------------------------------------------------------------
module ppec_back
    import ppec_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    input  logic [entry_bits(COORD_BITS)-1:0]   i_q_data,
    output logic                                o_q_pop,
    output logic                                empty,
    input  logic                                pop,
    output logic [1:0]                          o_kind,
    output logic signed [COORD_BITS-1:0]        o_out_start_x,
    output logic signed [COORD_BITS-1:0]        o_out_start_y,
    output logic signed [COORD_BITS-1:0]        o_out_start_z,
    output logic signed [COORD_BITS-1:0]        o_out_end_x,
    output logic signed [COORD_BITS-1:0]        o_out_end_y,
    output logic signed [COORD_BITS-1:0]        o_out_end_z,
    output logic [1:0]                          o_verdict,
    output logic [1:0]                          o_cap_progress,
    output logic                                o_last_result
);

    localparam int DW = dist_bits(COORD_BITS);
    localparam int EW = entry_bits(COORD_BITS);
    localparam int SW = DW + 1;
    localparam int TW = SW + 2;
    localparam int NW = $clog2(COORD_BITS);
    localparam logic [NW-1:0] LAST_BIT = NW'(COORD_BITS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_PT    = 3'd3;
    localparam logic [2:0] S_CAP   = 3'd4;
    localparam logic [2:0] S_EDGE  = 3'd5;
    localparam logic [2:0] S_SUM   = 3'd6;

    logic [2:0]                   r_state;
    logic [NW-1:0]                r_cnt;
    logic [COORD_BITS-1:0]        r_a [3];
    logic [COORD_BITS-1:0]        r_b [3];
    logic                         r_n1;
    logic                         r_fin;
    logic [DW-1:0]                r_ad1;
    logic [DW-1:0]                r_ad2;
    logic [SW-1:0]                r_sum;
    logic [SW-1:0]                r_rem [3];
    logic [COORD_BITS-1:0]        r_quo [3];
    logic [COORD_BITS-1:0]        r_mag [3];
    logic                         r_dneg [3];
    logic                         r_cap_started;
    logic                         r_cap_completed;
    logic                         r_saw_in;
    logic                         r_saw_out;
    logic [COORD_BITS-1:0]        r_cs [3];
    logic [COORD_BITS-1:0]        r_ce [3];
    logic                         r_ov;
    logic [1:0]                   r_o_kind;
    logic [COORD_BITS-1:0]        r_o_s [3];
    logic [COORD_BITS-1:0]        r_o_e [3];
    logic [1:0]                   r_o_verdict;
    logic [1:0]                   r_o_prog;
    logic                         r_o_last;

    logic [COORD_BITS-1:0]        q_p [6];
    logic signed [DW-1:0]         q_d1;
    logic signed [DW-1:0]         q_d2;
    logic                         q_o1;
    logic                         q_o2;
    logic                         q_fin;
    logic [TW-1:0]                t [3];
    logic [SW-1:0]                n_rem [3];
    logic [COORD_BITS-1:0]        n_quo [3];
    logic [COORD_BITS:0]          delta [3];
    logic [COORD_BITS-1:0]        n_mag [3];
    logic [COORD_BITS-1:0]        c [3];
    logic [1:0]                   digit [3];
    logic                         emit;
    logic [1:0]                   verdict;
    logic [1:0]                   prog;

    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;
    assign emit    = !r_ov && (r_state == S_CAP || r_state == S_EDGE || r_state == S_SUM);
    assign empty   = !r_ov;

    assign q_d1  = i_q_data[2*DW+2 : DW+3];
    assign q_d2  = i_q_data[DW+2 : 3];
    assign q_o1  = i_q_data[2];
    assign q_o2  = i_q_data[1];
    assign q_fin = i_q_data[0];

    assign verdict = !r_saw_out ? VERDICT_KEPT : (!r_saw_in ? VERDICT_DISCARDED
                                                            : VERDICT_CLIPPED);
    assign prog    = r_cap_completed ? CAP_DONE : (r_cap_started ? CAP_OPEN : CAP_NONE);

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            q_p[j] = i_q_data[EW-1-j*COORD_BITS -: COORD_BITS];
        end
        for (int i = 0; i < 3; i++) begin
            delta[i] = {r_b[i][COORD_BITS-1], r_b[i]} - {r_a[i][COORD_BITS-1], r_a[i]};
            n_mag[i] = delta[i][COORD_BITS] ? COORD_BITS'(-delta[i])
                                            : delta[i][COORD_BITS-1:0];
            t[i] = {1'b0, r_rem[i], 1'b0}
                 + (r_mag[i][COORD_BITS-1] ? TW'(r_ad1) : TW'(0));
            if (t[i] >= {1'b0, r_sum, 1'b0}) begin
                digit[i] = 2'd2;
                n_rem[i] = SW'(t[i] - {1'b0, r_sum, 1'b0});
            end else if (t[i] >= TW'(r_sum)) begin
                digit[i] = 2'd1;
                n_rem[i] = SW'(t[i] - TW'(r_sum));
            end else begin
                digit[i] = 2'd0;
                n_rem[i] = SW'(t[i]);
            end
            n_quo[i] = {r_quo[i][COORD_BITS-2:0], 1'b0} + COORD_BITS'(digit[i]);
            c[i]     = r_dneg[i] ? r_a[i] - r_quo[i] : r_a[i] + r_quo[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_cnt           <= '0;
            r_cap_started   <= 1'b0;
            r_cap_completed <= 1'b0;
            r_saw_in        <= 1'b0;
            r_saw_out       <= 1'b0;
            r_ov            <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_cs[i] <= '0;
                r_ce[i] <= '0;
            end
        end else begin
            if (emit) begin
                r_ov <= 1'b1;
            end else if (pop) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_saw_out <= r_saw_out | q_o1 | q_o2;
                        r_saw_in  <= r_saw_in | !q_o1 | !q_o2;
                        if (q_d1[DW-1] && q_d2[DW-1]) begin
                            r_state <= q_fin ? S_SUM : S_IDLE;
                        end else if (q_d1[DW-1] || q_d2[DW-1]) begin
                            r_state <= S_SETUP;
                        end else begin
                            r_state <= S_EDGE;
                        end
                    end
                end
                S_SETUP: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + NW'(1);
                    if (r_cnt == LAST_BIT) begin
                        r_state <= S_PT;
                    end
                end
                S_PT: begin
                    if (!r_cap_started) begin
                        r_cap_started <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            r_cs[i] <= c[i];
                        end
                        r_state <= S_EDGE;
                    end else begin
                        r_cap_completed <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            r_ce[i] <= c[i];
                        end
                        r_state <= S_CAP;
                    end
                end
                S_CAP: begin
                    if (emit) begin
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    if (emit) begin
                        r_state <= r_fin ? S_SUM : S_IDLE;
                    end
                end
                S_SUM: begin
                    if (emit) begin
                        r_cap_started   <= 1'b0;
                        r_cap_completed <= 1'b0;
                        r_saw_in        <= 1'b0;
                        r_saw_out       <= 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            r_cs[i] <= '0;
                            r_ce[i] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    for (int i = 0; i < 3; i++) begin
                        r_a[i] <= q_p[i];
                        r_b[i] <= q_p[3+i];
                    end
                    r_n1  <= q_d1[DW-1];
                    r_fin <= q_fin;
                    r_ad1 <= q_d1[DW-1] ? DW'(-q_d1) : DW'(q_d1);
                    r_ad2 <= q_d2[DW-1] ? DW'(-q_d2) : DW'(q_d2);
                end
            end
            S_SETUP: begin
                r_sum <= SW'(r_ad1) + SW'(r_ad2);
                for (int i = 0; i < 3; i++) begin
                    r_rem[i]  <= '0;
                    r_quo[i]  <= '0;
                    r_mag[i]  <= n_mag[i];
                    r_dneg[i] <= delta[i][COORD_BITS];
                end
            end
            S_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= n_rem[i];
                    r_quo[i] <= n_quo[i];
                    r_mag[i] <= {r_mag[i][COORD_BITS-2:0], 1'b0};
                end
            end
            S_PT: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_n1) begin
                        r_a[i] <= c[i];
                    end else begin
                        r_b[i] <= c[i];
                    end
                end
            end
            default: begin
            end
        endcase
        if (emit) begin
            r_o_verdict <= VERDICT_KEPT;
            r_o_prog    <= CAP_NONE;
            r_o_last    <= 1'b0;
            case (r_state)
                S_CAP: begin
                    r_o_kind <= KIND_CAP;
                    for (int i = 0; i < 3; i++) begin
                        r_o_s[i] <= r_cs[i];
                        r_o_e[i] <= r_ce[i];
                    end
                end
                S_EDGE: begin
                    r_o_kind <= KIND_EDGE;
                    for (int i = 0; i < 3; i++) begin
                        r_o_s[i] <= r_a[i];
                        r_o_e[i] <= r_b[i];
                    end
                end
                default: begin
                    r_o_kind    <= KIND_SUMMARY;
                    r_o_verdict <= verdict;
                    r_o_prog    <= prog;
                    r_o_last    <= 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        r_o_s[i] <= r_cs[i];
                        r_o_e[i] <= r_ce[i];
                    end
                end
            endcase
        end
    end

    assign o_kind         = r_o_kind;
    assign o_out_start_x  = r_o_s[0];
    assign o_out_start_y  = r_o_s[1];
    assign o_out_start_z  = r_o_s[2];
    assign o_out_end_x    = r_o_e[0];
    assign o_out_end_y    = r_o_e[1];
    assign o_out_end_z    = r_o_e[2];
    assign o_verdict      = r_o_verdict;
    assign o_cap_progress = r_o_prog;
    assign o_last_result  = r_o_last;

`ifndef SYNTH
    a_cap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cap_completed |-> r_cap_started)
        else $error("cap completed without a start");
    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !pop |=> r_ov)
        else $error("result beat dropped before pop");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !i_q_empty && r_state == S_IDLE)
        else $error("queue popped outside idle");
`endif

endmodule

// ===== sv/polygon_plane_edge_clipper_core.sv =====
// ----------------------------------------------------------------------------
// polygon_plane_edge_clipper_core
// Clips polygon edges against a configured plane and summarizes each polygon.
// ----------------------------------------------------------------------------
// An edge is taken in one beat while full is low; the front works out the
// two plane distances (one shared multiplier), then hands the edge to a
// two-entry queue. The back emits an edge that needs no clipping as it is,
// and runs a crossing edge through setup, the divider (one quotient bit per
// cycle, three coordinates side by side) and the crossing point before it
// emits the clipped edge. The one-beat output register can be refilled in
// the cycle after its pop. Results leave through that output register read
// with pop.
module polygon_plane_edge_clipper_core
    import ppec_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_start_z,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic signed [COORD_BITS-1:0] i_end_z,
    input  logic                         i_final_edge,
    output logic                         empty,
    input  logic                         pop,
    output logic [1:0]                   o_kind,
    output logic signed [COORD_BITS-1:0] o_out_start_x,
    output logic signed [COORD_BITS-1:0] o_out_start_y,
    output logic signed [COORD_BITS-1:0] o_out_start_z,
    output logic signed [COORD_BITS-1:0] o_out_end_x,
    output logic signed [COORD_BITS-1:0] o_out_end_y,
    output logic signed [COORD_BITS-1:0] o_out_end_z,
    output logic [1:0]                   o_verdict,
    output logic [1:0]                   o_cap_progress,
    output logic                         o_last_result,
    input  logic                         i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [CFG_W-1:0]             i_cfg_data
);

    localparam int EW = entry_bits(COORD_BITS);

    logic [CFG_W-1:0] r_normal_x;
    logic [CFG_W-1:0] r_normal_y;
    logic [CFG_W-1:0] r_normal_z;
    logic [CFG_W-1:0] r_plane_offset;
    logic [CFG_W-1:0] r_keep_bias;

    logic             q_push;
    logic             q_full;
    logic [EW-1:0]    q_wdata;
    logic             q_pop;
    logic             q_empty;
    logic [EW-1:0]    q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_x     <= '0;
            r_normal_y     <= '0;
            r_normal_z     <= NORMAL_Z_RESET;
            r_plane_offset <= '0;
            r_keep_bias    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_NORMAL_X:     r_normal_x     <= i_cfg_data;
                REG_NORMAL_Y:     r_normal_y     <= i_cfg_data;
                REG_NORMAL_Z:     r_normal_z     <= i_cfg_data;
                REG_PLANE_OFFSET: r_plane_offset <= i_cfg_data;
                REG_KEEP_BIAS:    r_keep_bias    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ppec_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_start_z      (i_start_z),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_end_z        (i_end_z),
        .i_final_edge   (i_final_edge),
        .i_normal_x     (r_normal_x),
        .i_normal_y     (r_normal_y),
        .i_normal_z     (r_normal_z),
        .i_plane_offset (r_plane_offset),
        .i_keep_bias    (r_keep_bias),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_data       (q_wdata)
    );

    ppec_queue #(
        .WIDTH(EW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    ppec_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_data       (q_rdata),
        .o_q_pop        (q_pop),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_out_start_x  (o_out_start_x),
        .o_out_start_y  (o_out_start_y),
        .o_out_start_z  (o_out_start_z),
        .o_out_end_x    (o_out_end_x),
        .o_out_end_y    (o_out_end_y),
        .o_out_end_z    (o_out_end_z),
        .o_verdict      (o_verdict),
        .o_cap_progress (o_cap_progress),
        .o_last_result  (o_last_result)
    );

endmodule

// ===== sim/tb_polygon_plane_edge_clipper_core.sv =====
// ----------------------------------------------------------------------------
// tb_polygon_plane_edge_clipper_core
// Streams polygon edges through the plane clipper under several plane
// settings and handshake pressures, predicts every beat and checks each one.
// ----------------------------------------------------------------------------
import ppec_pkg::*;

typedef logic signed [31:0]  t_coord;
typedef logic signed [127:0] t_dist;

typedef struct {
    logic [1:0] kind;
    t_coord     sx, sy, sz, ex, ey, ez;
    logic [1:0] verdict;
    logic [1:0] prog;
    logic       last;
} t_clip_beat;

class clip_scoreboard;
    t_clip_beat expected_beats[$];
    int         errors;
    t_coord     normal[3];
    t_coord     offset;
    t_coord     bias;
    bit         cap_started, cap_completed, saw_inside, saw_outside;
    t_coord     cap_from[3], cap_to[3];

    function new();
        normal[0] = 0;
        normal[1] = 0;
        normal[2] = NORMAL_Z_RESET;
        offset    = 0;
        bias      = 0;
        errors    = 0;
        clear_polygon();
    endfunction

    function void clear_polygon();
        cap_started   = 0;
        cap_completed = 0;
        saw_inside    = 0;
        saw_outside   = 0;
        for (int i = 0; i < 3; i++) begin
            cap_from[i] = 0;
            cap_to[i]   = 0;
        end
    endfunction

    function void add_beat(t_clip_beat b);
        expected_beats.insert(expected_beats.size(), b);
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
        case (addr)
            REG_NORMAL_X:     normal[0] = data;
            REG_NORMAL_Y:     normal[1] = data;
            REG_NORMAL_Z:     normal[2] = data;
            REG_PLANE_OFFSET: offset = data;
            REG_KEEP_BIAS:    bias = data;
            default: ;
        endcase
    endfunction

    function t_dist plane_distance(t_coord p[3]);
        t_dist s;
        t_dist n;
        t_dist c;
        s = offset;
        s = s <<< NORM_FRAC;
        for (int i = 0; i < 3; i++) begin
            n = normal[i];
            c = p[i];
            s = s + n * c;
        end
        return s;
    endfunction

    function t_coord crossing(t_coord a, t_coord b, t_dist ad1, t_dist sum);
        t_dist a_w;
        t_dist delta;
        t_dist mag;
        t_dist step;
        a_w   = a;
        delta = b;
        delta = delta - a_w;
        mag   = delta < 0 ? -delta : delta;
        step  = (mag * ad1) / sum;
        return delta < 0 ? t_coord'(a_w - step) : t_coord'(a_w + step);
    endfunction

    function t_clip_beat make_beat(logic [1:0] kind, t_coord a[3], t_coord b[3],
                                   logic [1:0] verdict, logic [1:0] prog, logic last);
        t_clip_beat r;
        r.kind = kind;
        r.sx = a[0]; r.sy = a[1]; r.sz = a[2];
        r.ex = b[0]; r.ey = b[1]; r.ez = b[2];
        r.verdict = verdict;
        r.prog    = prog;
        r.last    = last;
        return r;
    endfunction

    function void note_edge(t_coord p1[3], t_coord p2[3], bit fin);
        t_dist      d1, d2, thr, ad1, sum;
        bit         n1, n2;
        t_coord     a[3], b[3], c[3];
        logic [1:0] verdict, prog;
        d1  = plane_distance(p1);
        d2  = plane_distance(p2);
        thr = bias;
        thr = thr <<< NORM_FRAC;
        if (d1 < thr) saw_outside = 1; else saw_inside = 1;
        if (d2 < thr) saw_outside = 1; else saw_inside = 1;
        n1 = d1 < 0;
        n2 = d2 < 0;
        if (!(n1 && n2)) begin
            a = p1;
            b = p2;
            if (n1 || n2) begin
                ad1 = n1 ? -d1 : d1;
                sum = ad1 + (n2 ? -d2 : d2);
                for (int i = 0; i < 3; i++) begin
                    c[i] = crossing(p1[i], p2[i], ad1, sum);
                    if (n1) a[i] = c[i]; else b[i] = c[i];
                end
                if (!cap_started) begin
                    cap_from    = c;
                    cap_started = 1;
                end else begin
                    cap_to        = c;
                    cap_completed = 1;
                    add_beat(make_beat(KIND_CAP, cap_from, cap_to,
                                       VERDICT_KEPT, CAP_NONE, 1'b0));
                end
            end
            add_beat(make_beat(KIND_EDGE, a, b, VERDICT_KEPT, CAP_NONE, 1'b0));
        end
        if (fin) begin
            verdict = !saw_outside ? VERDICT_KEPT :
                      (!saw_inside ? VERDICT_DISCARDED : VERDICT_CLIPPED);
            prog = cap_completed ? CAP_DONE : (cap_started ? CAP_OPEN : CAP_NONE);
            add_beat(make_beat(KIND_SUMMARY, cap_from, cap_to, verdict, prog, 1'b1));
            clear_polygon();
        end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] exp);
        errors++;
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $realtime);
    endtask

    task check_beat(t_clip_beat got);
        t_clip_beat e;
        if (expected_beats.size() == 0) begin
            report("unexpected beat kind", got.kind, 0);
            return;
        end
        e = expected_beats.pop_front();
        if (got.kind    !== e.kind)    report("kind", got.kind, e.kind);
        if (got.sx      !== e.sx)      report("out_start_x", got.sx, e.sx);
        if (got.sy      !== e.sy)      report("out_start_y", got.sy, e.sy);
        if (got.sz      !== e.sz)      report("out_start_z", got.sz, e.sz);
        if (got.ex      !== e.ex)      report("out_end_x", got.ex, e.ex);
        if (got.ey      !== e.ey)      report("out_end_y", got.ey, e.ey);
        if (got.ez      !== e.ez)      report("out_end_z", got.ez, e.ez);
        if (got.verdict !== e.verdict) report("verdict", got.verdict, e.verdict);
        if (got.prog    !== e.prog)    report("cap_progress", got.prog, e.prog);
        if (got.last    !== e.last)    report("last_result", got.last, e.last);
    endtask
endclass

module tb_polygon_plane_edge_clipper_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 120;

    logic i_clk, i_rst_n, push, full, empty, pop;
    t_coord i_start_x, i_start_y, i_start_z, i_end_x, i_end_y, i_end_z;
    logic i_final_edge;
    logic [1:0] o_kind, o_verdict, o_cap_progress;
    t_coord o_out_start_x, o_out_start_y, o_out_start_z;
    t_coord o_out_end_x, o_out_end_y, o_out_end_z;
    logic o_last_result;
    logic i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0] i_cfg_data;

    clip_scoreboard clip_sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  recv_hold;
    int  cycles;

    polygon_plane_edge_clipper_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_start_x(i_start_x), .i_start_y(i_start_y), .i_start_z(i_start_z),
        .i_end_x(i_end_x), .i_end_y(i_end_y), .i_end_z(i_end_z),
        .i_final_edge(i_final_edge), .empty(empty), .pop(pop),
        .o_kind(o_kind), .o_out_start_x(o_out_start_x), .o_out_start_y(o_out_start_y),
        .o_out_start_z(o_out_start_z), .o_out_end_x(o_out_end_x),
        .o_out_end_y(o_out_end_y), .o_out_end_z(o_out_end_z), .o_verdict(o_verdict),
        .o_cap_progress(o_cap_progress), .o_last_result(o_last_result),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_polygon_plane_edge_clipper_core: done, errors");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || recv_hold)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_clip_beat got;
        if (i_rst_n && pop && !empty) begin
            got.kind = o_kind;
            got.sx = o_out_start_x; got.sy = o_out_start_y; got.sz = o_out_start_z;
            got.ex = o_out_end_x;   got.ey = o_out_end_y;   got.ez = o_out_end_z;
            got.verdict = o_verdict;
            got.prog    = o_cap_progress;
            got.last    = o_last_result;
            clip_sb.check_beat(got);
        end
    end

    task send_edge(t_coord s[3], t_coord e[3], bit fin);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_start_x <= s[0]; i_start_y <= s[1]; i_start_z <= s[2];
        i_end_x <= e[0];   i_end_y <= e[1];   i_end_z <= e[2];
        i_final_edge <= fin;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        clip_sb.note_edge(s, e, fin);
    endtask

    task drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (clip_sb.expected_beats.size() != 0) @(posedge i_clk);
    endtask

    task write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        clip_sb.set_reg(addr, data);
    endtask

    task set_plane(t_coord nx, t_coord ny, t_coord nz, t_coord w, t_coord kb);
        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        write_reg(REG_NORMAL_X, nx);
        write_reg(REG_NORMAL_Y, ny);
        write_reg(REG_NORMAL_Z, nz);
        write_reg(REG_PLANE_OFFSET, w);
        write_reg(REG_KEEP_BIAS, kb);
    endtask

    function automatic t_coord rand_coord();
        int r;
        r = $urandom_range(99);
        if (r < 5)  return 32'sh7FFF_FFFF;
        if (r < 10) return 32'sh8000_0000;
        if (r < 25) return $urandom;
        return $signed($urandom_range(32'h000A_0000)) - 32'sh0005_0000;
    endfunction

    function automatic t_coord rand_normal();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 32'sh4000_0000;
        if (r == 1) return -32'sh4000_0000;
        if (r == 2) return 0;
        return $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
    endfunction

    task send_polygon(int sides);
        t_coord v[6][3];
        for (int i = 0; i < sides; i++)
            for (int k = 0; k < 3; k++) v[i][k] = rand_coord();
        for (int i = 0; i < sides; i++)
            send_edge(v[i], v[(i + 1) % sides], i == sides - 1);
    endtask

    task send_noise();
        t_coord s[3], e[3];
        for (int k = 0; k < 3; k++) begin
            s[k] = $urandom;
            e[k] = $urandom;
        end
        send_edge(s, e, $urandom_range(3) == 0);
    endtask

    task random_items(int count);
        int sent;
        int sides;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) < 8) begin
                sides = $urandom_range(3, 6);
                send_polygon(sides);
                sent += sides;
            end else begin
                send_noise();
                sent++;
            end
        end
    endtask

    task directed();
        t_coord big, neg, one;
        big = 32'sh7FFF_FFFF;
        neg = 32'sh8000_0000;
        one = 32'sh0001_0000;
        send_edge('{0, 0, one}, '{one, 0, one}, 0);
        send_edge('{one, 0, one}, '{one, one, -one}, 0);
        send_edge('{one, one, -one}, '{0, one, -one}, 0);
        send_edge('{0, one, -one}, '{0, 0, one}, 1);
        send_edge('{big, neg, big}, '{neg, big, neg}, 0);
        send_edge('{neg, neg, neg}, '{big, big, big}, 0);
        send_edge('{0, 0, 0}, '{big, big, 0}, 1);
        send_edge('{0, 0, neg}, '{0, 0, -one}, 1);
        send_edge('{one, one, 0}, '{neg, big, 0}, 1);
        send_edge('{0, 0, -one}, '{0, 0, one}, 0);
        send_edge('{0, 0, one}, '{one, 0, -one}, 0);
        send_edge('{one, 0, -one}, '{one, one, one}, 0);
        send_edge('{one, one, one}, '{0, 0, -one}, 1);
        send_edge('{0, 0, one}, '{0, 0, one}, 1);
    endtask

    initial begin
        clip_sb = new();
        cycles = 0;
        i_rst_n = 0;
        push = 0;
        pop = 0;
        recv_hold = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_start_x = 0; i_start_y = 0; i_start_z = 0;
        i_end_x = 0;   i_end_y = 0;   i_end_z = 0;
        i_final_edge = 0;
        i_cfg_we = 0;
        i_cfg_addr = REG_NORMAL_X;
        i_cfg_data = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed();
        set_plane(0, 0, 32'sh4000_0000, 0, 32'sh0001_0000);
        directed();

        set_plane(rand_normal(), rand_normal(), rand_normal(), $urandom, $urandom);
        random_items(20);

        send_idle_pct = 81;
        set_plane(32'sh4000_0000, -32'sh4000_0000, 0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        random_items(10);
        set_plane(-32'sh4000_0000, 32'sh4000_0000, -32'sh4000_0000,
                  32'sh8000_0000, 32'sh7FFF_FFFF);
        random_items(10);

        send_idle_pct = 0;
        recv_stall_pct = 81;
        set_plane(rand_normal(), rand_normal(), rand_normal(),
                  $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000,
                  $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
        random_items(20);

        recv_stall_pct = 9;
        send_idle_pct = 9;
        set_plane(rand_normal(), rand_normal(), rand_normal(), 0, 0);
        recv_hold = 1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                recv_hold = 0;
            end
        join_none
        random_items(20);
        drain();
        random_items(12);

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (clip_sb.errors == 0)
            $display("tb_polygon_plane_edge_clipper_core: done, clean");
        else
            $display("tb_polygon_plane_edge_clipper_core: done, errors");
        $finish;
    end

    final begin
    end
endmodule

// ===== polygon_plane_edge_clipper_core.f =====
sv/ppec_pkg.sv
sv/ppec_queue.sv
sv/ppec_front.sv
sv/ppec_back.sv
sv/polygon_plane_edge_clipper_core.sv
sim/tb_polygon_plane_edge_clipper_core.sv
